### design/tdfd_pkg.sv
// ----------------------------------------------------------------------------
// tdfd_pkg
// Shared types, constants and helpers of the text header fragment deframer.
// ----------------------------------------------------------------------------
package tdfd_pkg;

  localparam int NumberWidth = 16;
  localparam int MaxPayload  = 1024;
  localparam int LengthWidth = $clog2(MaxPayload + 1);

  localparam logic [7:0] AsciiColon = 8'h3A;
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiNine  = 8'h39;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_NAME    = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_HDR_END = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       datagram_end;
  } in_word_t;

  typedef struct packed {
    kind_e                  kind;
    logic [NumberWidth-1:0] total_fragments;
    logic [NumberWidth-1:0] fragment_number;
    logic [LengthWidth-1:0] payload_length;
    logic [7:0]             byte_out;
    logic                   final_fragment;
    logic                   last_of_fragment;
    logic                   error;
  } out_word_t;

  typedef struct packed {
    logic      produced;
    out_word_t word;
  } parse_res_t;

  // acc * 10 + digit, saturating at the all-ones value
  function automatic logic [NumberWidth-1:0] add_digit(
    input logic [NumberWidth-1:0] acc,
    input logic [3:0]             digit
  );
    logic [NumberWidth+3:0] sum;
    sum = {acc, 3'b000} + {3'b000, acc, 1'b0} + {{NumberWidth{1'b0}}, digit};
    if (sum[NumberWidth+3:NumberWidth] != 4'd0) begin
      return {NumberWidth{1'b1}};
    end
    return sum[NumberWidth-1:0];
  endfunction

endpackage

### design/tdfd_in_if.sv
// ----------------------------------------------------------------------------
// tdfd_in_if
// Valid/ready channel carrying one datagram byte per word.
// ----------------------------------------------------------------------------
interface tdfd_in_if;
  import tdfd_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### design/tdfd_out_if.sv
// ----------------------------------------------------------------------------
// tdfd_out_if
// Valid/ready channel carrying one deframer result per word.
// ----------------------------------------------------------------------------
interface tdfd_out_if;
  import tdfd_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### design/tdfd_parse.sv
// ----------------------------------------------------------------------------
// tdfd_parse
// Parser state and the single-pass update that turns one byte into at most
// one result.
// ----------------------------------------------------------------------------
module tdfd_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  tdfd_pkg::in_word_t    word_i,
  output tdfd_pkg::parse_res_t  res_o
);
  import tdfd_pkg::*;

  localparam logic [2:0] PhTotal   = 3'd0;
  localparam logic [2:0] PhNumber  = 3'd1;
  localparam logic [2:0] PhSize    = 3'd2;
  localparam logic [2:0] PhName    = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;
  localparam logic [2:0] PhDrop    = 3'd5;

  logic [2:0]             phase_q, phase_d;
  logic [NumberWidth-1:0] tot_q, tot_d;
  logic [NumberWidth-1:0] num_q, num_d;
  logic [NumberWidth-1:0] len_q, len_d;
  logic                   closed_q, closed_d;
  logic [LengthWidth-1:0] rem_q, rem_d;
  logic                   over_q, over_d;

  logic                   is_colon;
  logic                   is_digit;
  logic [3:0]             digit;
  logic [LengthWidth-1:0] rem_dec;
  logic                   produced;
  kind_e                  kind;
  logic [7:0]             byte_val;
  logic                   last;
  logic                   err;

  assign is_colon = (word_i.data_byte == AsciiColon);
  assign is_digit = (word_i.data_byte >= AsciiZero) && (word_i.data_byte <= AsciiNine);
  assign digit    = 4'(word_i.data_byte - AsciiZero);
  assign rem_dec  = (rem_q != '0) ? rem_q - LengthWidth'(1) : '0;

  always_comb begin
    phase_d  = phase_q;
    tot_d    = tot_q;
    num_d    = num_q;
    len_d    = len_q;
    closed_d = closed_q;
    rem_d    = rem_q;
    over_d   = over_q;
    produced = 1'b0;
    kind     = KIND_HEADER;
    byte_val = 8'd0;
    last     = 1'b0;
    err      = 1'b0;

    unique case (phase_q)
      PhTotal, PhNumber, PhSize: begin
        if (is_colon) begin
          closed_d = 1'b0;
          if (phase_q == PhSize) begin
            if (len_q > NumberWidth'(MaxPayload)) begin
              len_d  = NumberWidth'(MaxPayload);
              over_d = 1'b1;
            end
            phase_d  = PhName;
            produced = 1'b1;
            last     = word_i.datagram_end;
            err      = word_i.datagram_end;
          end else begin
            phase_d = phase_q + 3'd1;
          end
        end else if (!closed_q && is_digit) begin
          priority case (phase_q)
            PhTotal:  tot_d = add_digit(tot_q, digit);
            PhNumber: num_d = add_digit(num_q, digit);
            default:  len_d = add_digit(len_q, digit);
          endcase
        end else begin
          closed_d = 1'b1;
        end
        if (!produced && word_i.datagram_end) begin
          produced = 1'b1;
          last     = 1'b1;
          err      = 1'b1;
        end
      end
      PhName: begin
        produced = 1'b1;
        if (is_colon) begin
          kind  = KIND_HDR_END;
          rem_d = len_q[LengthWidth-1:0];
          if (len_q == '0) begin
            last    = 1'b1;
            phase_d = PhDrop;
          end else begin
            phase_d = PhPayload;
            last    = word_i.datagram_end;
            err     = word_i.datagram_end;
          end
        end else begin
          kind     = KIND_NAME;
          byte_val = word_i.data_byte;
          last     = word_i.datagram_end;
          err      = word_i.datagram_end;
        end
      end
      PhPayload: begin
        produced = 1'b1;
        kind     = KIND_PAYLOAD;
        byte_val = word_i.data_byte;
        rem_d    = rem_dec;
        if (rem_dec == '0) begin
          last    = 1'b1;
          phase_d = PhDrop;
        end else begin
          last = word_i.datagram_end;
          err  = word_i.datagram_end;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.produced              = produced;
  assign res_o.word.kind             = kind;
  assign res_o.word.total_fragments  = tot_d;
  assign res_o.word.fragment_number  = num_d;
  assign res_o.word.payload_length   = len_d[LengthWidth-1:0];
  assign res_o.word.byte_out         = byte_val;
  assign res_o.word.final_fragment   = (num_d == tot_d);
  assign res_o.word.last_of_fragment = last;
  assign res_o.word.error            = err | over_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhTotal;
      tot_q    <= '0;
      num_q    <= '0;
      len_q    <= '0;
      closed_q <= 1'b0;
      rem_q    <= '0;
      over_q   <= 1'b0;
    end else if (adv_i) begin
      if (word_i.datagram_end) begin
        phase_q  <= PhTotal;
        tot_q    <= '0;
        num_q    <= '0;
        len_q    <= '0;
        closed_q <= 1'b0;
        rem_q    <= '0;
        over_q   <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        tot_q    <= tot_d;
        num_q    <= num_d;
        len_q    <= len_d;
        closed_q <= closed_d;
        rem_q    <= rem_d;
        over_q   <= over_d;
      end
    end
  end

endmodule

### design/tdfd_out_reg.sv
// ----------------------------------------------------------------------------
// tdfd_out_reg
// Result register driving the output channel; reports when it cannot load.
// ----------------------------------------------------------------------------
module tdfd_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  tdfd_pkg::parse_res_t res_i,
  output logic                 busy_o,
  tdfd_out_if.source           out_o
);
  import tdfd_pkg::*;

  logic      valid_q, valid_d;
  out_word_t word_q;

  assign busy_o = valid_q && !out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_i.produced;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.produced) begin
      word_q <= res_i.word;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.payload = word_q;

endmodule

### design/text_header_fragment_deframer_unit.sv
// ----------------------------------------------------------------------------
// text_header_fragment_deframer_unit
// Byte-serial deframer for total:number:size:name:payload fragment datagrams.
// ----------------------------------------------------------------------------
// Takes one datagram byte per word and gives at most one result word per
// byte: a header word at the third colon, one word per name byte, an
// end-of-header word at the fourth colon, then one word per payload byte.
// Each byte is held in the input register, where the parser state is
// updated, and its result is loaded into the output register when the byte
// leaves it, so throughput is one byte per cycle while the sink keeps up.
// The ready path runs through the parser stage and the result
// register; a stalled result holds the input register and then the input.
module text_header_fragment_deframer_unit (
  input logic        clk_i,
  input logic        rst_ni,
  tdfd_in_if.sink    in_i,
  tdfd_out_if.source out_o
);
  import tdfd_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  in_word_t   s1_word_q;
  logic       busy;
  logic       adv;
  parse_res_t res;

  assign adv        = s1_valid_q && !busy;
  assign in_i.ready = !s1_valid_q || adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_i.valid && in_i.ready) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_word_q <= in_i.payload;
    end
  end

  tdfd_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .word_i (s1_word_q),
    .res_o  (res)
  );

  tdfd_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (adv),
    .res_i  (res),
    .busy_o (busy),
    .out_o  (out_o)
  );

endmodule
